// File: hw/rtl/cet_pkg.sv
// Package: types, register indexes and state encoding for the cubic ease tween.
`default_nettype none
package cet_pkg;

  typedef struct packed {
    logic        kind;
    logic [31:0] step_time;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               finished;
  } out_t;

  typedef enum logic [2:0] {
    REG_EASE_MODE = 3'd0,
    REG_START_X   = 3'd1,
    REG_START_Y   = 3'd2,
    REG_START_Z   = 3'd3,
    REG_END_X     = 3'd4,
    REG_END_Y     = 3'd5,
    REG_END_Z     = 3'd6,
    REG_DURATION  = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_IN    = 2'd0,
    MODE_OUT   = 2'd1,
    MODE_INOUT = 2'd2,
    MODE_ZERO  = 2'd3
  } ease_mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_PREP,
    ST_SQ,
    ST_CUBE,
    ST_FRAC,
    ST_LERP,
    ST_OUT
  } state_e;

  localparam logic [30:0] OneQ30 = 31'h4000_0000;
  localparam int unsigned DivSteps = 32;

endpackage
`default_nettype wire

// File: hw/rtl/cet_div.sv
// Restoring divider: 32 quotient bits of num / den, one bit per cycle.
`default_nettype none
module cet_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        busy_o,
  output logic [31:0] quo_o
);

  logic [63:0] num_q, num_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [31:0] quo_q, quo_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [33:0] trial;
  logic [32:0] shifted;

  // the quotient fits 32 bits: caller guarantees num < den * 2^32
  always_comb begin
    num_d   = num_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    shifted = {rem_q[31:0], num_q[63]};
    trial   = {1'b0, shifted} - {2'b00, den_q};
    if (start_i) begin
      num_d  = {num_i[31:0], 32'd0};
      rem_d  = {1'b0, num_i[63:32]};
      den_d  = den_i;
      cnt_d  = 6'(cet_pkg::DivSteps);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[62:0], 1'b0};
      if (!trial[33]) begin
        rem_d = trial[32:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

// File: hw/rtl/cubic_ease_position_tween.sv
// Top level: cubic eased 3-D position tween with a shared divider and multiplier.
`default_nettype none
// A restart transaction and a tick while idle are handled in the idle state;
// a tick that passes the duration, or in the zero-vector mode, goes straight
// to the output state; an eased tick first runs the bit-serial divider for
// the progress fraction, then one shared 33x33 multiplier used in turn for
// the square, the cube and the three axis interpolations. After a tick with a
// result, input ready is low from acceptance until the result has been taken.
module cubic_ease_position_tween (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cet_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cet_pkg::out_t  out_data_o,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [31:0]    cfg_wdata_i
);

  logic [1:0]  mode_q;
  logic [31:0] sx_q, sy_q, sz_q, ex_q, ey_q, ez_q, dur_q;
  logic [31:0] elapsed_q, elapsed_d;
  logic        moving_q, moving_d;
  cet_pkg::state_e state_q, state_d;
  cet_pkg::out_t   res_q, res_d;
  logic [31:0] frac_q, frac_d;
  logic        second_q, second_d;
  logic [1:0]  axis_q, axis_d;

  logic        div_start, div_busy;
  logic [63:0] div_num;
  logic [31:0] div_quo;
  logic [32:0] sum;
  logic [31:0] sat;
  logic [32:0] two_e;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [31:0] sq;
  logic [31:0] cube;
  logic [31:0] s_sel, e_sel;
  logic signed [32:0] diff;
  logic signed [31:0] lerp;

  cet_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (dur_q),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 2'd0;
      sx_q <= '0; sy_q <= '0; sz_q <= '0;
      ex_q <= '0; ey_q <= '0; ez_q <= '0;
      dur_q <= 32'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cet_pkg::REG_EASE_MODE: mode_q <= cfg_wdata_i[1:0];
        cet_pkg::REG_START_X:   sx_q <= cfg_wdata_i;
        cet_pkg::REG_START_Y:   sy_q <= cfg_wdata_i;
        cet_pkg::REG_START_Z:   sz_q <= cfg_wdata_i;
        cet_pkg::REG_END_X:     ex_q <= cfg_wdata_i;
        cet_pkg::REG_END_Y:     ey_q <= cfg_wdata_i;
        cet_pkg::REG_END_Z:     ez_q <= cfg_wdata_i;
        cet_pkg::REG_DURATION:  dur_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign sum   = {1'b0, elapsed_q} + {1'b0, in_data_i.step_time};
  assign sat   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign two_e = {elapsed_q, 1'b0};

  always_comb begin
    case (axis_q)
      2'd0:    begin s_sel = sx_q; e_sel = ex_q; end
      2'd1:    begin s_sel = sy_q; e_sel = ey_q; end
      default: begin s_sel = sz_q; e_sel = ez_q; end
    endcase
  end
  assign diff = 33'(signed'(e_sel)) - 33'(signed'(s_sel));

  // shared multiplier operands
  always_comb begin
    mul_a = 33'(signed'({1'b0, frac_q}));
    mul_b = 33'(signed'({1'b0, frac_q}));
    case (state_q)
      cet_pkg::ST_CUBE: mul_a = 33'(signed'({1'b0, res_q.pos_x}));
      cet_pkg::ST_LERP: mul_b = diff;
      default: ;
    endcase
  end
  assign mul_p = 66'(mul_a) * 66'(mul_b);
  assign sq    = mul_p[61:30];
  assign cube  = mul_p[61:30];
  assign lerp  = 32'(signed'(s_sel)) + 32'(mul_p >>> 30);

  always_comb begin
    state_d = state_q;
    if (!in_valid_i && state_q == cet_pkg::ST_IDLE) state_d = state_q;
    case (state_q)
      cet_pkg::ST_IDLE: begin
        if (in_valid_i && in_data_i.kind == 1'b0 && moving_q) begin
          if (sat > dur_q || mode_q == cet_pkg::MODE_ZERO) state_d = cet_pkg::ST_OUT;
          else state_d = cet_pkg::ST_PREP;
        end
      end
      cet_pkg::ST_PREP: state_d = cet_pkg::ST_DIV;
      cet_pkg::ST_DIV:  if (!div_busy) state_d = cet_pkg::ST_SQ;
      cet_pkg::ST_SQ:   state_d = cet_pkg::ST_CUBE;
      cet_pkg::ST_CUBE: state_d = cet_pkg::ST_FRAC;
      cet_pkg::ST_FRAC: state_d = cet_pkg::ST_LERP;
      cet_pkg::ST_LERP: if (axis_q == 2'd2) state_d = cet_pkg::ST_OUT;
      cet_pkg::ST_OUT:  if (out_ready_i) state_d = cet_pkg::ST_IDLE;
      default:          state_d = cet_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    elapsed_d = elapsed_q;
    moving_d  = moving_q;
    res_d     = res_q;
    frac_d    = frac_q;
    second_d  = second_q;
    axis_d    = axis_q;
    div_start = 1'b0;
    div_num   = '0;
    case (state_q)
      cet_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.kind) begin
            elapsed_d = '0;
            moving_d  = 1'b1;
          end else if (moving_q) begin
            elapsed_d = sat;
            res_d.finished = 1'b0;
            if (sat > dur_q) begin
              res_d.pos_x = ex_q; res_d.pos_y = ey_q; res_d.pos_z = ez_q;
              res_d.finished = 1'b1;
              moving_d = 1'b0;
            end else if (mode_q == cet_pkg::MODE_ZERO) begin
              res_d.pos_x = '0; res_d.pos_y = '0; res_d.pos_z = '0;
            end
          end
        end
      end
      cet_pkg::ST_PREP: begin
        div_start = 1'b1;
        second_d  = 1'b0;
        axis_d    = 2'd0;
        if (mode_q == cet_pkg::MODE_INOUT) begin
          if (two_e < {1'b0, dur_q}) begin
            div_num = {31'd0, elapsed_q, 1'b0} << 30;
          end else begin
            second_d = 1'b1;
            div_num  = {31'd0, 33'(dur_q - elapsed_q) << 1} << 30;
          end
        end else begin
          div_num = {32'd0, elapsed_q} << 30;
        end
      end
      cet_pkg::ST_DIV: begin
        if (!div_busy) begin
          // zero duration: progress is full, so only ease in starts from one
          if (dur_q == '0) begin
            frac_d = (mode_q == cet_pkg::MODE_IN) ? {1'b0, cet_pkg::OneQ30} : '0;
          end else if (mode_q == cet_pkg::MODE_OUT) begin
            frac_d = {1'b0, cet_pkg::OneQ30} - div_quo;
          end else begin
            frac_d = div_quo;
          end
        end
      end
      cet_pkg::ST_SQ:   res_d.pos_x = sq;
      cet_pkg::ST_CUBE: frac_d = cube;
      cet_pkg::ST_FRAC: begin
        case (mode_q)
          cet_pkg::MODE_OUT: frac_d = {1'b0, cet_pkg::OneQ30} - frac_q;
          cet_pkg::MODE_INOUT:
            frac_d = second_q ? {1'b0, cet_pkg::OneQ30} - {1'b0, frac_q[31:1]}
                              : {1'b0, frac_q[31:1]};
          default: ;
        endcase
      end
      cet_pkg::ST_LERP: begin
        case (axis_q)
          2'd0:    res_d.pos_x = lerp;
          2'd1:    res_d.pos_y = lerp;
          default: res_d.pos_z = lerp;
        endcase
        axis_d = axis_q + 2'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cet_pkg::ST_IDLE;
      elapsed_q <= '0;
      moving_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      elapsed_q <= elapsed_d;
      moving_q  <= moving_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    frac_q   <= frac_d;
    second_q <= second_d;
    axis_q   <= axis_d;
  end

  assign in_ready_o  = (state_q == cet_pkg::ST_IDLE);
  assign out_valid_o = (state_q == cet_pkg::ST_OUT);
  assign out_data_o  = res_q;

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready and valid together");
  a_fin_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.finished |-> !moving_q)
    else $error("finished while moving");
  a_div_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> state_q == cet_pkg::ST_DIV) else $error("divider busy out of turn");
`endif

endmodule
`default_nettype wire
